### rtl/tf_pkg.sv
// Twofish-256 package: shared types, constants and the pure functions
// (q permutations, h layers, MDS and RS mixing). No dependencies.
`default_nettype none
package tf_pkg;

  localparam int KeyRegs    = 4;
  localparam int CfgIdxW    = 3;
  localparam int PairAW     = 5;   // 20 subkey pairs
  localparam int SubkeyPairs = 20;
  localparam int SboxDepth  = 256;

  localparam logic [8:0] RsPoly  = 9'h14d;
  localparam logic [8:0] MdsPoly = 9'h169;

  // subkey pair addresses: pair p holds {K[2p+1], K[2p]}
  localparam logic [PairAW-1:0] PairInWhiteLo  = 5'd0;
  localparam logic [PairAW-1:0] PairInWhiteHi  = 5'd1;
  localparam logic [PairAW-1:0] PairOutWhiteLo = 5'd2;
  localparam logic [PairAW-1:0] PairOutWhiteHi = 5'd3;
  localparam logic [PairAW-1:0] PairRoundBase  = 5'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEYS,
    ST_SWORD,
    ST_SBOX,
    ST_WIN_A,
    ST_WIN_B,
    ST_WIN_C,
    ST_RREAD,
    ST_RCALC,
    ST_WOUT_A,
    ST_WOUT_B,
    ST_WOUT_C
  } tf_state_t;

  // nibble tables, entry n at bits 4n+3:4n
  localparam logic [63:0] Q0T0 = 64'h4ACE_95B0_23F6_D718;
  localparam logic [63:0] Q0T1 = 64'hD907_6A4F_5321_8BCE;
  localparam logic [63:0] Q0T2 = 64'h1742_3F8C_09D6_E5AB;
  localparam logic [63:0] Q0T3 = 64'hAC58_03B9_E621_4F7D;
  localparam logic [63:0] Q1T0 = 64'h5CA0_4913_E67F_DB82;
  localparam logic [63:0] Q1T1 = 64'h809F_5AD6_73C4_B2E1;
  localparam logic [63:0] Q1T2 = 64'hF3B2_8DE0_A961_57C4;
  localparam logic [63:0] Q1T3 = 64'hA802_F746_ED3C_159B;

  // MDS rows, column j at bits 8j+7:8j
  localparam logic [31:0] MdsRow0 = 32'h5B5B_EF01;
  localparam logic [31:0] MdsRow1 = 32'h01EF_EF5B;
  localparam logic [31:0] MdsRow2 = 32'hEF01_5BEF;
  localparam logic [31:0] MdsRow3 = 32'h5BEF_01EF;

  localparam logic [63:0] RsRow0 = 64'h9EDB_585A_8755_A401;
  localparam logic [63:0] RsRow1 = 64'hE568_C61E_F382_56A4;
  localparam logic [63:0] RsRow2 = 64'h193D_AE47_C1FC_A102;
  localparam logic [63:0] RsRow3 = 64'h039E_DB58_5A87_55A4;

  function automatic logic [3:0] nib(input logic [63:0] tab, input logic [3:0] idx);
    return tab[{idx, 2'b00} +: 4];
  endfunction

  function automatic logic [7:0] qperm(input logic which, input logic [7:0] x);
    logic [3:0] a, b, a2, b2;
    a  = x[7:4];
    b  = x[3:0];
    a2 = a ^ b;
    b2 = a ^ {b[0], b[3:1]} ^ {a[0], 3'b000};
    a  = nib(which ? Q1T0 : Q0T0, a2);
    b  = nib(which ? Q1T1 : Q0T1, b2);
    a2 = a ^ b;
    b2 = a ^ {b[0], b[3:1]} ^ {a[0], 3'b000};
    a  = nib(which ? Q1T2 : Q0T2, a2);
    b  = nib(which ? Q1T3 : Q0T3, b2);
    return {b, a};
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [8:0] poly);
    logic [8:0] x;
    logic [7:0] y, r;
    x = {1'b0, a};
    y = b;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (y[0]) r = r ^ x[7:0];
      y = y >> 1;
      x = x << 1;
      if (x[8]) x = x ^ poly;
    end
    return r;
  endfunction

  function automatic logic [31:0] mds_row(input logic [1:0] i);
    case (i)
      2'd0:    return MdsRow0;
      2'd1:    return MdsRow1;
      2'd2:    return MdsRow2;
      default: return MdsRow3;
    endcase
  endfunction

  function automatic logic [31:0] mds_mix(input logic [31:0] y);
    logic [31:0] z, row;
    logic [7:0]  acc;
    z = '0;
    for (int i = 0; i < 4; i++) begin
      row = mds_row(2'(i));
      acc = '0;
      for (int j = 0; j < 4; j++) acc = acc ^ gf_mul(row[8*j +: 8], y[8*j +: 8], MdsPoly);
      z[8*i +: 8] = acc;
    end
    return z;
  endfunction

  function automatic logic [63:0] rs_row(input logic [1:0] r);
    case (r)
      2'd0:    return RsRow0;
      2'd1:    return RsRow1;
      2'd2:    return RsRow2;
      default: return RsRow3;
    endcase
  endfunction

  function automatic logic [31:0] rs_word(input logic [63:0] k);
    logic [31:0] s;
    logic [63:0] row;
    logic [7:0]  acc;
    s = '0;
    for (int r = 0; r < 4; r++) begin
      row = rs_row(2'(r));
      acc = '0;
      for (int j = 0; j < 8; j++) acc = acc ^ gf_mul(row[8*j +: 8], k[8*j +: 8], RsPoly);
      s[8*r +: 8] = acc;
    end
    return s;
  endfunction

  // q layers of h, l0..l3 being list entries 0..3
  function automatic logic [31:0] h_layers(input logic [31:0] x, input logic [31:0] l0,
                                           input logic [31:0] l1, input logic [31:0] l2,
                                           input logic [31:0] l3);
    logic [7:0] y0, y1, y2, y3;
    y0 = qperm(1'b1, x[7:0])   ^ l3[7:0];
    y1 = qperm(1'b0, x[15:8])  ^ l3[15:8];
    y2 = qperm(1'b0, x[23:16]) ^ l3[23:16];
    y3 = qperm(1'b1, x[31:24]) ^ l3[31:24];
    y0 = qperm(1'b1, y0) ^ l2[7:0];
    y1 = qperm(1'b1, y1) ^ l2[15:8];
    y2 = qperm(1'b0, y2) ^ l2[23:16];
    y3 = qperm(1'b0, y3) ^ l2[31:24];
    y0 = qperm(1'b1, qperm(1'b0, qperm(1'b0, y0) ^ l1[7:0])   ^ l0[7:0]);
    y1 = qperm(1'b0, qperm(1'b0, qperm(1'b1, y1) ^ l1[15:8])  ^ l0[15:8]);
    y2 = qperm(1'b1, qperm(1'b1, qperm(1'b0, y2) ^ l1[23:16]) ^ l0[23:16]);
    y3 = qperm(1'b0, qperm(1'b1, qperm(1'b1, y3) ^ l1[31:24]) ^ l0[31:24]);
    return {y3, y2, y1, y0};
  endfunction

endpackage
`default_nettype wire

### rtl/tf_key_ram.sv
// Round subkey memory: 20 pairs of 32-bit subkeys, one write and one
// registered read port. Depends on tf_pkg.
`default_nettype none
module tf_key_ram
  import tf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [PairAW-1:0] waddr,
  input  wire logic [63:0]       wdata,
  input  wire logic [PairAW-1:0] raddr,
  output logic      [63:0]       rdata
);

  logic [63:0] mem [SubkeyPairs];
  logic [63:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/tf_sbox_ram.sv
// Keyed S-box memory: four 256x8 banks, one per byte lane, written together
// and read at two independent byte addresses per bank. Depends on tf_pkg.
`default_nettype none
module tf_sbox_ram
  import tf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        we,
  input  wire logic [7:0]  waddr,
  input  wire logic [31:0] wdata,
  input  wire logic [31:0] raddr_a,
  input  wire logic [31:0] raddr_b,
  output logic      [31:0] rdata_a,
  output logic      [31:0] rdata_b
);

  logic [7:0]  bank_mem [4][SboxDepth];
  logic [31:0] rdata_a_r, rdata_b_r;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      if (we) bank_mem[j][waddr] <= wdata[8*j +: 8];
      rdata_a_r[8*j +: 8] <= bank_mem[j][raddr_a[8*j +: 8]];
      rdata_b_r[8*j +: 8] <= bank_mem[j][raddr_b[8*j +: 8]];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule
`default_nettype wire

### rtl/twofish256_block_encrypt_core.sv
// Twofish-256 encryption core: key registers, schedule and round sequencer.
// Depends on tf_pkg, tf_key_ram and tf_sbox_ram.
//
// Usage: write the 256-bit key through cfg_we/cfg_index/cfg_wdata (indexes
// 0..3, 64 bits each, little-endian) while the core is idle. A block is
// taken when start is high and busy is low; the four plaintext words are
// captured then. The ciphertext appears on out_cipher_word0..3, flagged by
// out_valid for exactly one cycle; the receiver must take it then.
// Key schedule: the first block after reset or after any key write first
// runs the schedule: subkey pairs (ST_KEYS), RS words (ST_SWORD) and the
// S-box fill (ST_SBOX), all before input whitening.
// Encryption: input whitening (ST_WIN_A..C), 16 rounds of ST_RREAD and
// ST_RCALC, then output whitening (ST_WOUT_A..C); out_valid rises the cycle
// after it, and a new block can be started in that same cycle. Each round
// has a read state and a compute state because the S-box read address
// comes from the previous round's result and the bank reads are registered.
// Reset clears the key to zero, marks the schedule stale and idles the core.
`default_nettype none
module twofish256_block_encrypt_core
  import tf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [31:0]        in_plain_word0,
  input  wire logic [31:0]        in_plain_word1,
  input  wire logic [31:0]        in_plain_word2,
  input  wire logic [31:0]        in_plain_word3,
  output logic                    out_valid,
  output logic      [31:0]        out_cipher_word0,
  output logic      [31:0]        out_cipher_word1,
  output logic      [31:0]        out_cipher_word2,
  output logic      [31:0]        out_cipher_word3,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [63:0]        cfg_wdata
);

  tf_state_t   state_r, state_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [3:0]  rnd_r, rnd_nxt;
  logic        sched_ready_r;
  logic        sched_done;
  logic [63:0] key_r [KeyRegs];
  logic [31:0] sword_r [4];
  logic [31:0] r0_r, r1_r, r2_r, r3_r;
  logic [31:0] r0_nxt, r1_nxt, r2_nxt, r3_nxt;
  logic [31:0] c0_r, c1_r, c2_r, c3_r;
  logic        out_valid_r, out_valid_nxt;
  logic        accept;

  // memory ports
  logic              kr_we;
  logic [PairAW-1:0] kr_raddr;
  logic [63:0]       kr_wdata, kr_rdata;
  logic              sb_we;
  logic [31:0]       sb_wdata, sb_rdata_a, sb_rdata_b, sb_raddr_b;

  // schedule datapath
  logic [7:0]  x_even, x_odd;
  logic [31:0] ka, kb, t0, t1;
  logic [31:0] kb_raw, ksum, ksum2;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  assign x_even = {cnt_r[6:0], 1'b0};
  assign x_odd  = {cnt_r[6:0], 1'b1};
  assign ka = mds_mix(h_layers({4{x_even}}, key_r[0][31:0], key_r[1][31:0],
                               key_r[2][31:0], key_r[3][31:0]));
  assign kb = {kb_raw[23:0], kb_raw[31:24]};
  assign kb_raw = mds_mix(h_layers({4{x_odd}}, key_r[0][63:32], key_r[1][63:32],
                                   key_r[2][63:32], key_r[3][63:32]));
  assign ksum  = ka + kb;
  assign ksum2 = ka + {kb[30:0], 1'b0};
  assign kr_wdata = {ksum2[22:0], ksum2[31:23], ksum};

  assign sb_wdata   = h_layers({4{cnt_r}}, sword_r[3], sword_r[2], sword_r[1], sword_r[0]);
  assign sb_raddr_b = {r1_r[23:0], r1_r[31:24]};

  assign t0 = mds_mix(sb_rdata_a);
  assign t1 = mds_mix(sb_rdata_b);

  tf_key_ram u_key_ram (
    .clk   (clk),
    .we    (kr_we),
    .waddr (cnt_r[PairAW-1:0]),
    .wdata (kr_wdata),
    .raddr (kr_raddr),
    .rdata (kr_rdata)
  );

  tf_sbox_ram u_sbox_ram (
    .clk     (clk),
    .we      (sb_we),
    .waddr   (cnt_r),
    .wdata   (sb_wdata),
    .raddr_a (r0_r),
    .raddr_b (sb_raddr_b),
    .rdata_a (sb_rdata_a),
    .rdata_b (sb_rdata_b)
  );

  always_comb begin
    logic [31:0] f0, f1;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rnd_nxt       = rnd_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    r2_nxt        = r2_r;
    r3_nxt        = r3_r;
    out_valid_nxt = 1'b0;
    kr_we         = 1'b0;
    kr_raddr      = PairInWhiteLo;
    sb_we         = 1'b0;
    sched_done    = 1'b0;
    f0 = t0 + t1 + kr_rdata[31:0];
    f1 = t0 + {t1[30:0], 1'b0} + kr_rdata[63:32];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          r0_nxt    = in_plain_word0;
          r1_nxt    = in_plain_word1;
          r2_nxt    = in_plain_word2;
          r3_nxt    = in_plain_word3;
          cnt_nxt   = '0;
          rnd_nxt   = '0;
          state_nxt = sched_ready_r ? ST_WIN_A : ST_KEYS;
        end
      end
      ST_KEYS: begin
        kr_we = 1'b1;
        if (cnt_r == 8'(SubkeyPairs - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SWORD;
        end else begin
          cnt_nxt = cnt_r + 8'd1;
        end
      end
      ST_SWORD: state_nxt = ST_SBOX;
      ST_SBOX: begin
        sb_we   = 1'b1;
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_r == 8'(SboxDepth - 1)) begin
          sched_done = 1'b1;
          state_nxt  = ST_WIN_A;
        end
      end
      ST_WIN_A: begin
        kr_raddr  = PairInWhiteLo;
        state_nxt = ST_WIN_B;
      end
      ST_WIN_B: begin
        r0_nxt    = r0_r ^ kr_rdata[31:0];
        r1_nxt    = r1_r ^ kr_rdata[63:32];
        kr_raddr  = PairInWhiteHi;
        state_nxt = ST_WIN_C;
      end
      ST_WIN_C: begin
        r2_nxt    = r2_r ^ kr_rdata[31:0];
        r3_nxt    = r3_r ^ kr_rdata[63:32];
        state_nxt = ST_RREAD;
      end
      ST_RREAD: begin
        kr_raddr  = PairRoundBase + {1'b0, rnd_r};
        state_nxt = ST_RCALC;
      end
      ST_RCALC: begin
        // round with the half swap folded in
        r0_nxt    = {r2_r[0] ^ f0[0], r2_r[31:1] ^ f0[31:1]};
        r1_nxt    = {r3_r[30:0], r3_r[31]} ^ f1;
        r2_nxt    = r0_r;
        r3_nxt    = r1_r;
        rnd_nxt   = rnd_r + 4'd1;
        state_nxt = (rnd_r == 4'd15) ? ST_WOUT_A : ST_RREAD;
      end
      ST_WOUT_A: begin
        kr_raddr  = PairOutWhiteLo;
        state_nxt = ST_WOUT_B;
      end
      ST_WOUT_B: begin
        kr_raddr  = PairOutWhiteHi;
        state_nxt = ST_WOUT_C;
      end
      ST_WOUT_C: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      rnd_r         <= '0;
      out_valid_r   <= 1'b0;
      sched_ready_r <= 1'b0;
      for (int i = 0; i < KeyRegs; i++) key_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index < CfgIdxW'(KeyRegs))) begin
        key_r[cfg_index[1:0]] <= cfg_wdata;
        sched_ready_r         <= 1'b0;
      end else if (sched_done) begin
        sched_ready_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    r0_r <= r0_nxt;
    r1_r <= r1_nxt;
    r2_r <= r2_nxt;
    r3_r <= r3_nxt;
    if (state_r == ST_SWORD) begin
      for (int i = 0; i < 4; i++) sword_r[i] <= rs_word(key_r[i]);
    end
    if (state_r == ST_WOUT_B) begin
      c0_r <= r2_r ^ kr_rdata[31:0];
      c1_r <= r3_r ^ kr_rdata[63:32];
    end
    if (state_r == ST_WOUT_C) begin
      c2_r <= r0_r ^ kr_rdata[31:0];
      c3_r <= r1_r ^ kr_rdata[63:32];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cipher_word0 = c0_r;
  assign out_cipher_word1 = c1_r;
  assign out_cipher_word2 = c2_r;
  assign out_cipher_word3 = c3_r;

`ifndef NO_ASSERTIONS
  a_strobe_after_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_WOUT_C))
    else $error("result strobe without output whitening");

  a_stale_key_runs_sched: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy && !sched_ready_r) |=> (state_r == ST_KEYS))
    else $error("stale schedule not rebuilt");

  a_sixteen_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WOUT_A) |-> (rnd_r == 4'd0 && $past(state_r == ST_RCALC)))
    else $error("round count off at output whitening");
`endif

endmodule
`default_nettype wire

### sim/twofish256_block_encrypt_core_test.sv
// Self-checking testbench for twofish256_block_encrypt_core: directed table plus
// random blocks and key changes, checked against an in-bench Twofish-256 model.
// Depends on tf_pkg (register index width) and the core RTL.
`timescale 1ns / 100ps
module twofish256_block_encrypt_core_test;

  typedef logic [3:0][31:0] block_t;

  localparam logic [tf_pkg::CfgIdxW-1:0] REG_KEY0 = 0;
  localparam logic [tf_pkg::CfgIdxW-1:0] REG_KEY1 = 1;
  localparam logic [tf_pkg::CfgIdxW-1:0] REG_KEY2 = 2;
  localparam logic [tf_pkg::CfgIdxW-1:0] REG_KEY3 = 3;
  localparam logic [tf_pkg::CfgIdxW-1:0] REG_SPARE = 6;
  localparam int CYCLE_LIMIT = 600000;

  logic clk, rst_n, start, busy, out_valid, cfg_we;
  logic [31:0] in_plain_word0, in_plain_word1, in_plain_word2, in_plain_word3;
  logic [31:0] out_cipher_word0, out_cipher_word1, out_cipher_word2, out_cipher_word3;
  logic [tf_pkg::CfgIdxW-1:0] cfg_index;
  logic [63:0] cfg_wdata;

  twofish256_block_encrypt_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_plain_word0(in_plain_word0), .in_plain_word1(in_plain_word1),
    .in_plain_word2(in_plain_word2), .in_plain_word3(in_plain_word3),
    .out_valid(out_valid),
    .out_cipher_word0(out_cipher_word0), .out_cipher_word1(out_cipher_word1),
    .out_cipher_word2(out_cipher_word2), .out_cipher_word3(out_cipher_word3),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  bit [3:0] qt [2][4][16] = '{
    '{'{4'h8,4'h1,4'h7,4'hD,4'h6,4'hF,4'h3,4'h2,4'h0,4'hB,4'h5,4'h9,4'hE,4'hC,4'hA,4'h4},
      '{4'hE,4'hC,4'hB,4'h8,4'h1,4'h2,4'h3,4'h5,4'hF,4'h4,4'hA,4'h6,4'h7,4'h0,4'h9,4'hD},
      '{4'hB,4'hA,4'h5,4'hE,4'h6,4'hD,4'h9,4'h0,4'hC,4'h8,4'hF,4'h3,4'h2,4'h4,4'h7,4'h1},
      '{4'hD,4'h7,4'hF,4'h4,4'h1,4'h2,4'h6,4'hE,4'h9,4'hB,4'h3,4'h0,4'h8,4'h5,4'hC,4'hA}},
    '{'{4'h2,4'h8,4'hB,4'hD,4'hF,4'h7,4'h6,4'hE,4'h3,4'h1,4'h9,4'h4,4'h0,4'hA,4'hC,4'h5},
      '{4'h1,4'hE,4'h2,4'hB,4'h4,4'hC,4'h3,4'h7,4'h6,4'hD,4'hA,4'h5,4'hF,4'h9,4'h0,4'h8},
      '{4'h4,4'hC,4'h7,4'h5,4'h1,4'h6,4'h9,4'hA,4'h0,4'hE,4'hD,4'h8,4'h2,4'hB,4'h3,4'hF},
      '{4'hB,4'h9,4'h5,4'h1,4'hC,4'h3,4'hD,4'hE,4'h6,4'h4,4'h7,4'hF,4'h2,4'h0,4'h8,4'hA}}};
  bit [7:0] mds_m [4][4] = '{'{8'h01,8'hEF,8'h5B,8'h5B}, '{8'h5B,8'hEF,8'hEF,8'h01},
                             '{8'hEF,8'h5B,8'h01,8'hEF}, '{8'hEF,8'h01,8'hEF,8'h5B}};
  bit [7:0] rs_m [4][8] = '{
    '{8'h01,8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E},
    '{8'hA4,8'h56,8'h82,8'hF3,8'h1E,8'hC6,8'h68,8'hE5},
    '{8'h02,8'hA1,8'hFC,8'hC1,8'h47,8'hAE,8'h3D,8'h19},
    '{8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E,8'h03}};

  // predictor state
  logic [63:0] key_mirror [4];
  logic [31:0] subkey [40];
  logic [7:0]  sbox_mem [1024];
  bit          sched_fresh;

  block_t cipher_q [$];
  int     fail_count;
  int     cycle_count;

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b, logic [8:0] poly);
    logic [8:0] x;
    logic [7:0] r;
    x = {1'b0, a};
    r = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= x[7:0];
      x = x << 1;
      if (x[8]) x ^= poly;
    end
    return r;
  endfunction

  function automatic logic [7:0] qbox(int sel, logic [7:0] v);
    logic [3:0] a, b, a2, b2;
    a = v[7:4];
    b = v[3:0];
    for (int s = 0; s < 4; s += 2) begin
      a2 = a ^ b;
      b2 = a ^ {b[0], b[3:1]} ^ {a[0], 3'b000};
      a = qt[sel][s][a2];
      b = qt[sel][s+1][b2];
    end
    return {b, a};
  endfunction

  function automatic logic [31:0] mds_apply(logic [31:0] y);
    logic [31:0] z;
    logic [7:0] acc;
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int j = 0; j < 4; j++) acc ^= gmul(mds_m[i][j], y[8*j +: 8], 9'h169);
      z[8*i +: 8] = acc;
    end
    return z;
  endfunction

  // h without the final MDS; l0..l3 in list order, l3 applied first
  function automatic logic [31:0] h_core(logic [31:0] x, logic [31:0] l0, logic [31:0] l1,
                                         logic [31:0] l2, logic [31:0] l3);
    logic [7:0] y0, y1, y2, y3;
    y0 = qbox(1, x[7:0]) ^ l3[7:0];
    y1 = qbox(0, x[15:8]) ^ l3[15:8];
    y2 = qbox(0, x[23:16]) ^ l3[23:16];
    y3 = qbox(1, x[31:24]) ^ l3[31:24];
    y0 = qbox(1, y0) ^ l2[7:0];
    y1 = qbox(1, y1) ^ l2[15:8];
    y2 = qbox(0, y2) ^ l2[23:16];
    y3 = qbox(0, y3) ^ l2[31:24];
    y0 = qbox(1, qbox(0, qbox(0, y0) ^ l1[7:0]) ^ l0[7:0]);
    y1 = qbox(0, qbox(0, qbox(1, y1) ^ l1[15:8]) ^ l0[15:8]);
    y2 = qbox(1, qbox(1, qbox(0, y2) ^ l1[23:16]) ^ l0[23:16]);
    y3 = qbox(0, qbox(1, qbox(1, y3) ^ l1[31:24]) ^ l0[31:24]);
    return {y3, y2, y1, y0};
  endfunction

  task automatic build_schedule();
    logic [31:0] m [8];
    logic [31:0] a, b, y;
    logic [31:0] sw [4];
    logic [7:0] acc;
    for (int i = 0; i < 8; i++) m[i] = key_mirror[i/2][32*(i%2) +: 32];
    for (int i = 0; i < 20; i++) begin
      a = mds_apply(h_core((2*i) * 32'h01010101, m[0], m[2], m[4], m[6]));
      b = rol(mds_apply(h_core((2*i+1) * 32'h01010101, m[1], m[3], m[5], m[7])), 8);
      subkey[2*i] = a + b;
      subkey[2*i+1] = rol(a + 2*b, 9);
    end
    for (int i = 0; i < 4; i++)
      for (int r = 0; r < 4; r++) begin
        acc = 0;
        for (int j = 0; j < 8; j++) acc ^= gmul(rs_m[r][j], key_mirror[i][8*j +: 8], 9'h14d);
        sw[i][8*r +: 8] = acc;
      end
    for (int i = 0; i < 256; i++) begin
      y = h_core(i * 32'h01010101, sw[3], sw[2], sw[1], sw[0]);
      for (int j = 0; j < 4; j++) sbox_mem[256*j + i] = y[8*j +: 8];
    end
    sched_fresh = 1;
  endtask

  function automatic logic [31:0] gfun(logic [31:0] x);
    logic [31:0] y;
    for (int j = 0; j < 4; j++) y[8*j +: 8] = sbox_mem[256*j + x[8*j +: 8]];
    return mds_apply(y);
  endfunction

  function automatic block_t encrypt_block(block_t pt);
    logic [31:0] r0, r1, r2, r3, t0, t1, s;
    block_t ct;
    r0 = pt[0] ^ subkey[0];
    r1 = pt[1] ^ subkey[1];
    r2 = pt[2] ^ subkey[2];
    r3 = pt[3] ^ subkey[3];
    for (int rnd = 0; rnd < 16; rnd++) begin
      t0 = gfun(r0);
      t1 = gfun(rol(r1, 8));
      r2 = r2 ^ (t0 + t1 + subkey[2*rnd+8]);
      r2 = {r2[0], r2[31:1]};
      r3 = rol(r3, 1) ^ (t0 + 2*t1 + subkey[2*rnd+9]);
      s = r0; r0 = r2; r2 = s;
      s = r1; r1 = r3; r3 = s;
    end
    ct[0] = r2 ^ subkey[4];
    ct[1] = r3 ^ subkey[5];
    ct[2] = r0 ^ subkey[6];
    ct[3] = r1 ^ subkey[7];
    return ct;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %08h expected %08h at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  // stimulus drivers
  task automatic drain_wait();
    start <= 0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // leaves cfg_we high; send_block lowers it before the next block
  task automatic write_reg(logic [tf_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx < 4) begin
      key_mirror[idx] = val;
      sched_fresh = 0;
    end
  endtask

  task automatic send_block(block_t pt, bit typed, block_t typed_ct);
    block_t ct;
    cfg_we <= 0;
    start <= 1;
    {in_plain_word3, in_plain_word2, in_plain_word1, in_plain_word0} <= pt;
    do @(posedge clk); while (busy);
    if (!sched_fresh) build_schedule();
    ct = encrypt_block(pt);
    cipher_q.push_back(typed ? typed_ct : ct);
  endtask

  task automatic sender_gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 0;
      cfg_we <= 0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  typedef struct {
    bit          is_write;
    logic [tf_pkg::CfgIdxW-1:0] idx;
    logic [63:0] wval;
    block_t      pt;
    bit          typed;
    block_t      ct;
  } row_t;

  row_t plan [$];

  function automatic row_t blk_row(block_t pt, bit typed = 0, block_t ct = '0);
    row_t r;
    r.is_write = 0; r.idx = 0; r.wval = 0; r.pt = pt; r.typed = typed; r.ct = ct;
    return r;
  endfunction

  function automatic row_t wr_row(logic [tf_pkg::CfgIdxW-1:0] idx, logic [63:0] v);
    row_t r;
    r = blk_row('0);
    r.is_write = 1; r.idx = idx; r.wval = v;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    block_t want;
    if (rst_n && out_valid) begin
      if (cipher_q.size() == 0) begin
        $display("unexpected transaction at cycle %0d", cycle_count);
        fail_count++;
      end else begin
        want = cipher_q.pop_front();
        if (out_cipher_word0 !== want[0]) report_mismatch("cipher_word0", out_cipher_word0, want[0]);
        if (out_cipher_word1 !== want[1]) report_mismatch("cipher_word1", out_cipher_word1, want[1]);
        if (out_cipher_word2 !== want[2]) report_mismatch("cipher_word2", out_cipher_word2, want[2]);
        if (out_cipher_word3 !== want[3]) report_mismatch("cipher_word3", out_cipher_word3, want[3]);
      end
    end
  end

  initial begin
    int pct;
    block_t pt;
    fail_count = 0;
    cycle_count = 0;
    rst_n = 0;
    start = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    {in_plain_word3, in_plain_word2, in_plain_word1, in_plain_word0} = '0;
    for (int i = 0; i < 4; i++) key_mirror[i] = 0;
    sched_fresh = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // zero key straight after reset: published all-zero vector
    plan.push_back(blk_row('0, 1, {32'h6F21C80C, 32'h7001FCD7, 32'h1B2CC94D, 32'h9D73FF57}));
    plan.push_back(blk_row({4{32'hFFFF_FFFF}}));
    plan.push_back(blk_row({32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0}));
    plan.push_back(wr_row(REG_KEY0, '1));
    plan.push_back(wr_row(REG_KEY1, '1));
    plan.push_back(wr_row(REG_KEY2, '1));
    plan.push_back(wr_row(REG_KEY3, '1));
    plan.push_back(blk_row('0));
    plan.push_back(blk_row({4{32'hFFFF_FFFF}}));
    // out-of-range index must leave the key untouched
    plan.push_back(wr_row(REG_SPARE, 64'h0123_4567_89AB_CDEF));
    plan.push_back(blk_row({32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF}));
    plan.push_back(wr_row(REG_KEY0, 64'h0123_4567_89AB_CDEF));
    plan.push_back(wr_row(REG_KEY1, 64'hFEDC_BA98_7654_3210));
    plan.push_back(blk_row({32'hDEAD_BEEF, 32'h5555_AAAA, 32'h1234_5678, 32'h8000_0001}));
    plan.push_back(blk_row({32'hAAAA_5555, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h7FFF_FFFF}));
    plan.push_back(wr_row(REG_KEY0, '0));
    plan.push_back(wr_row(REG_KEY1, '0));
    plan.push_back(wr_row(REG_KEY2, '0));
    plan.push_back(wr_row(REG_KEY3, '0));
    plan.push_back(blk_row('0, 1, {32'h6F21C80C, 32'h7001FCD7, 32'h1B2CC94D, 32'h9D73FF57}));

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (i == 0 || !plan[i-1].is_write) drain_wait();
        write_reg(plan[i].idx, plan[i].wval);
      end else begin
        send_block(plan[i].pt, plan[i].typed, plan[i].ct);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      pct = (ph == 0) ? 6 : (ph == 1) ? 74 : 0;
      for (int n = 0; n < 150; n++) begin
        if (n % 50 == 25) begin
          drain_wait();
          for (int r = 0; r < 4; r++) begin
            case ($urandom_range(3))
              0: write_reg(REG_KEY0 + tf_pkg::CfgIdxW'(r), '0);
              1: write_reg(REG_KEY0 + tf_pkg::CfgIdxW'(r), '1);
              default: write_reg(REG_KEY0 + tf_pkg::CfgIdxW'(r), {$urandom, $urandom});
            endcase
          end
          if ($urandom_range(1))
            write_reg(tf_pkg::CfgIdxW'($urandom_range(4, 7)), {$urandom, $urandom});
        end
        if ((n % 50) > 40) sender_gap(0);
        else sender_gap(pct);
        pt = {rnd_word(), rnd_word(), rnd_word(), rnd_word()};
        send_block(pt, 0, '0);
      end
    end

    start <= 0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
